// ----- src/mtjs_pkg.sv -----
package mtjs_pkg;

   localparam int MAX_JOBS_DEF   = 32;
   localparam int SLOT_COUNT_DEF = 20;

   localparam logic       REQ_LOAD = 1'b0;
   localparam logic       REQ_TICK = 1'b1;

   localparam logic [1:0] CSR_MONTH_NUMBER  = 2'd0;
   localparam logic [1:0] CSR_DAYS_IN_MONTH = 2'd1;
   localparam logic [1:0] CSR_FIRST_WEEKDAY = 2'd2;

   localparam int ANY_MINUTE  = 0;
   localparam int ANY_HOUR    = 1;
   localparam int ANY_DAY     = 2;
   localparam int ANY_MONTH   = 3;
   localparam int ANY_WEEKDAY = 4;

   localparam logic [5:0]  LAST_MINUTE  = 6'd59;
   localparam logic [4:0]  LAST_HOUR    = 5'd23;
   localparam logic [2:0]  LAST_WEEKDAY = 3'd6;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [20:0] TOTAL_MAX    = 21'h1FFFFF;

   typedef struct packed {
      logic        req_type;
      logic [4:0]  job_index;
      logic        job_valid;
      logic [5:0]  match_minute;
      logic [4:0]  match_hour;
      logic [4:0]  match_day;
      logic [3:0]  match_month;
      logic [2:0]  match_weekday;
      logic [4:0]  any_mask;
      logic [15:0] duration;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  jobs_started;
      logic [4:0]  active_jobs;
      logic [4:0]  peak_active;
      logic [20:0] total_calls;
      logic [4:0]  busiest_job;
      logic [15:0] busiest_count;
      logic        month_done;
      logic        slot_overflow;
   } rsp_data_type;

   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [2:0]  weekday;
      logic [4:0]  any_mask;
      logic [15:0] duration;
   } job_entry_type;

   typedef struct packed {
      logic        alloc;
      logic        decay;
      logic [15:0] dur;
   } slot_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DECAY,
      ST_TALLY,
      ST_FINISH
   } seq_state_type;

endpackage

// ----- src/mtjs_chan_if.sv -----
interface mtjs_req_if;
   logic                       valid;
   logic                       ready;
   mtjs_pkg::req_data_type     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mtjs_rsp_if;
   logic                       valid;
   logic                       ready;
   mtjs_pkg::rsp_data_type     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/minute_tick_job_schedule_matcher_unit.sv -----
// Cron-style schedule matcher. A load transaction writes one job entry and is answered in the
// cycle after it is taken. A tick transaction simulates one minute (after the month is done it is
// answered without a walk): the job table and call-count memories are walked one entry a cycle
// through their single read port, each matching job takes the lowest free countdown slot (or
// flags an overflow if none is free), then the slots count down, the active slots are tallied and
// the calendar advances. One transaction is worked at a time; a new one is taken as soon as the
// previous response has left or is leaving. No clearing pass is needed after reset.
module minute_tick_job_schedule_matcher_unit #(
   parameter int MAX_JOBS   = mtjs_pkg::MAX_JOBS_DEF,
   parameter int SLOT_COUNT = mtjs_pkg::SLOT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mtjs_req_if.sink   req_ch,
   mtjs_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wdata
);

   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int AW = $clog2(SLOT_COUNT + 1);

   mtjs_pkg::seq_state_type st_ff, st_in;
   logic [IW-1:0]  walk_ff, walk_in;
   logic           pv_ff, pv_in;
   logic [IW-1:0]  pidx_ff, pidx_in;
   logic [5:0]     minute_ff, minute_in;
   logic [4:0]     hour_ff, hour_in;
   logic [4:0]     day_ff, day_in;
   logic [2:0]     wday_ff, wday_in;
   logic [3:0]     month_ff, month_in;
   logic [4:0]     days_ff, days_in;
   logic [5:0]     started_ff, started_in;
   logic           ovf_ff, ovf_in;
   logic [AW-1:0]  act_ff, act_in;
   logic [AW-1:0]  peak_ff, peak_in;
   logic [20:0]    total_ff, total_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   logic [15:0]    best_cnt_ff, best_cnt_in;
   logic           fin_ff, fin_in;
   logic           rsp_vld_ff, rsp_vld_in;

   logic                    req_acc, is_tick, ld_we, rd_en, hit, cnt_we, slot_full;
   logic [15:0]             cnt_inc, rd_count;
   logic [AW-1:0]           slot_active;
   mtjs_pkg::job_entry_type ld_entry, rd_entry;
   logic                    rd_jvalid;
   mtjs_pkg::slot_ctl_type  slot_ctl;

   assign req_ch.ready = (st_ff == mtjs_pkg::ST_IDLE) && (!rsp_vld_ff || rsp_ch.ready);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign is_tick      = req_acc && (req_ch.data.req_type == mtjs_pkg::REQ_TICK) && !fin_ff;
   assign ld_we        = req_acc && (req_ch.data.req_type == mtjs_pkg::REQ_LOAD) &&
                         ({4'd0, req_ch.data.job_index} < 9'(MAX_JOBS));

   assign ld_entry.minute   = req_ch.data.match_minute;
   assign ld_entry.hour     = req_ch.data.match_hour;
   assign ld_entry.day      = req_ch.data.match_day;
   assign ld_entry.month    = req_ch.data.match_month;
   assign ld_entry.weekday  = req_ch.data.match_weekday;
   assign ld_entry.any_mask = req_ch.data.any_mask;
   assign ld_entry.duration = req_ch.data.duration;

   mtjs_job_store #(.MAX_JOBS(MAX_JOBS), .IW(IW)) u_store (
      .clock     (clock),
      .reset     (reset),
      .ld_we     (ld_we),
      .ld_addr   (IW'(req_ch.data.job_index)),
      .ld_entry  (ld_entry),
      .ld_valid  (req_ch.data.job_valid),
      .rd_en     (rd_en),
      .rd_addr   (walk_ff),
      .cnt_we    (cnt_we),
      .cnt_addr  (pidx_ff),
      .cnt_data  (cnt_inc),
      .rd_entry  (rd_entry),
      .rd_jvalid (rd_jvalid),
      .rd_count  (rd_count)
   );

   mtjs_slot_bank #(.SLOT_COUNT(SLOT_COUNT), .AW(AW)) u_slots (
      .clock  (clock),
      .reset  (reset),
      .ctl    (slot_ctl),
      .full   (slot_full),
      .active (slot_active)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         mtjs_pkg::ST_IDLE: begin
            if (is_tick) st_in = mtjs_pkg::ST_WALK;
         end
         mtjs_pkg::ST_WALK: begin
            if (walk_ff == IW'(MAX_JOBS - 1)) st_in = mtjs_pkg::ST_DRAIN;
         end
         mtjs_pkg::ST_DRAIN:  st_in = mtjs_pkg::ST_DECAY;
         mtjs_pkg::ST_DECAY:  st_in = mtjs_pkg::ST_TALLY;
         mtjs_pkg::ST_TALLY:  st_in = mtjs_pkg::ST_FINISH;
         mtjs_pkg::ST_FINISH: st_in = mtjs_pkg::ST_IDLE;
         default:             st_in = mtjs_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      rd_en = 1'b0;
      case (st_ff)
         mtjs_pkg::ST_WALK: rd_en = 1'b1;
         default: begin
         end
      endcase
   end

   assign slot_ctl.decay = (st_ff == mtjs_pkg::ST_DECAY);

   // match stage, working on the entry read in the previous cycle
   assign hit = pv_ff && rd_jvalid &&
      (rd_entry.any_mask[mtjs_pkg::ANY_MINUTE]  || rd_entry.minute  == minute_ff) &&
      (rd_entry.any_mask[mtjs_pkg::ANY_HOUR]    || rd_entry.hour    == hour_ff) &&
      (rd_entry.any_mask[mtjs_pkg::ANY_DAY]     || rd_entry.day     == day_ff) &&
      (rd_entry.any_mask[mtjs_pkg::ANY_MONTH]   || rd_entry.month   == month_ff) &&
      (rd_entry.any_mask[mtjs_pkg::ANY_WEEKDAY] || rd_entry.weekday == wday_ff);

   assign cnt_inc        = rd_count + 16'd1;
   assign cnt_we         = hit && (rd_count != mtjs_pkg::COUNT_MAX);
   assign slot_ctl.alloc = hit;
   assign slot_ctl.dur   = rd_entry.duration;

   always_comb begin
      walk_in     = walk_ff;
      pv_in       = rd_en;
      pidx_in     = walk_ff;
      minute_in   = minute_ff;
      hour_in     = hour_ff;
      day_in      = day_ff;
      wday_in     = wday_ff;
      month_in    = month_ff;
      days_in     = days_ff;
      started_in  = started_ff;
      ovf_in      = ovf_ff;
      act_in      = act_ff;
      peak_in     = peak_ff;
      total_in    = total_ff;
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      fin_in      = fin_ff;
      rsp_vld_in  = rsp_vld_ff;

      if (rsp_vld_ff && rsp_ch.ready) rsp_vld_in = 1'b0;

      if (req_acc) begin
         started_in = '0;
         ovf_in     = 1'b0;
         walk_in    = '0;
         if (!is_tick) rsp_vld_in = 1'b1;
      end

      if (rd_en) walk_in = walk_ff + IW'(1);

      if (hit) begin
         started_in = started_ff + 6'd1;
         if (total_ff != mtjs_pkg::TOTAL_MAX) total_in = total_ff + 21'd1;
         if (cnt_we && ((cnt_inc > best_cnt_ff) ||
                        (cnt_inc == best_cnt_ff && pidx_ff < best_idx_ff))) begin
            best_cnt_in = cnt_inc;
            best_idx_in = pidx_ff;
         end
         if (slot_full) ovf_in = 1'b1;
      end

      if (st_ff == mtjs_pkg::ST_TALLY) act_in = slot_active;

      if (st_ff == mtjs_pkg::ST_FINISH) begin
         if (act_ff > peak_ff) peak_in = act_ff;
         rsp_vld_in = 1'b1;
         // calendar advance, holds after the last minute of the month
         if (minute_ff >= mtjs_pkg::LAST_MINUTE && hour_ff >= mtjs_pkg::LAST_HOUR &&
             day_ff >= days_ff) begin
            fin_in = 1'b1;
         end else if (minute_ff < mtjs_pkg::LAST_MINUTE) begin
            minute_in = minute_ff + 6'd1;
         end else begin
            minute_in = '0;
            if (hour_ff < mtjs_pkg::LAST_HOUR) begin
               hour_in = hour_ff + 5'd1;
            end else begin
               hour_in = '0;
               day_in  = day_ff + 5'd1;
               wday_in = (wday_ff >= mtjs_pkg::LAST_WEEKDAY) ? 3'd0 : wday_ff + 3'd1;
            end
         end
      end

      if (csr_we) begin
         case (csr_index)
            mtjs_pkg::CSR_MONTH_NUMBER:  month_in = csr_wdata[3:0];
            mtjs_pkg::CSR_DAYS_IN_MONTH: days_in  = csr_wdata;
            mtjs_pkg::CSR_FIRST_WEEKDAY: wday_in  = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= mtjs_pkg::ST_IDLE;
         walk_ff     <= '0;
         pv_ff       <= 1'b0;
         pidx_ff     <= '0;
         minute_ff   <= '0;
         hour_ff     <= '0;
         day_ff      <= 5'd1;
         wday_ff     <= '0;
         month_ff    <= '0;
         days_ff     <= 5'd31;
         started_ff  <= '0;
         ovf_ff      <= 1'b0;
         act_ff      <= '0;
         peak_ff     <= '0;
         total_ff    <= '0;
         best_idx_ff <= '0;
         best_cnt_ff <= '0;
         fin_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         st_ff       <= st_in;
         walk_ff     <= walk_in;
         pv_ff       <= pv_in;
         pidx_ff     <= pidx_in;
         minute_ff   <= minute_in;
         hour_ff     <= hour_in;
         day_ff      <= day_in;
         wday_ff     <= wday_in;
         month_ff    <= month_in;
         days_ff     <= days_in;
         started_ff  <= started_in;
         ovf_ff      <= ovf_in;
         act_ff      <= act_in;
         peak_ff     <= peak_in;
         total_ff    <= total_in;
         best_idx_ff <= best_idx_in;
         best_cnt_ff <= best_cnt_in;
         fin_ff      <= fin_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid              = rsp_vld_ff;
   assign rsp_ch.data.jobs_started  = started_ff;
   assign rsp_ch.data.active_jobs   = 5'(act_ff);
   assign rsp_ch.data.peak_active   = 5'(peak_ff);
   assign rsp_ch.data.total_calls   = total_ff;
   assign rsp_ch.data.busiest_job   = 5'(best_idx_ff);
   assign rsp_ch.data.busiest_count = best_cnt_ff;
   assign rsp_ch.data.month_done    = fin_ff;
   assign rsp_ch.data.slot_overflow = ovf_ff;

   a_cnt_rw_apart: assert property (@(posedge clock) disable iff (reset)
      cnt_we && rd_en |-> pidx_ff != walk_ff)
      else $error("count write and read hit the same entry");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      st_ff != mtjs_pkg::ST_IDLE |-> !rsp_vld_ff)
      else $error("response pending while a tick is in progress");

   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      st_ff == mtjs_pkg::ST_IDLE |-> act_ff <= peak_ff)
      else $error("peak below active count");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("call total decreased");

endmodule

// ----- src/mtjs_job_store.sv -----
module mtjs_job_store #(
   parameter int MAX_JOBS = mtjs_pkg::MAX_JOBS_DEF,
   parameter int IW       = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ld_we,
   input  logic [IW-1:0]           ld_addr,
   input  mtjs_pkg::job_entry_type ld_entry,
   input  logic                    ld_valid,
   input  logic                    rd_en,
   input  logic [IW-1:0]           rd_addr,
   input  logic                    cnt_we,
   input  logic [IW-1:0]           cnt_addr,
   input  logic [15:0]             cnt_data,
   output mtjs_pkg::job_entry_type rd_entry,
   output logic                    rd_jvalid,
   output logic [15:0]             rd_count
);

   mtjs_pkg::job_entry_type job_mem [MAX_JOBS];
   logic [15:0]             cnt_mem [MAX_JOBS];

   mtjs_pkg::job_entry_type entry_q_ff;
   logic [15:0]             cnt_q_ff;
   logic [IW-1:0]           raddr_ff, raddr_in;
   logic [MAX_JOBS-1:0]     jvld_ff, jvld_in;
   logic [MAX_JOBS-1:0]     cvld_ff, cvld_in;

   always_ff @(posedge clock) begin
      if (ld_we) begin
         job_mem[ld_addr] <= ld_entry;
      end
      if (rd_en) begin
         entry_q_ff <= job_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_data;
      end
      if (rd_en) begin
         cnt_q_ff <= cnt_mem[rd_addr];
      end
   end

   always_comb begin
      jvld_in  = jvld_ff;
      cvld_in  = cvld_ff;
      raddr_in = raddr_ff;
      if (ld_we) begin
         jvld_in[ld_addr] = ld_valid;
      end
      if (cnt_we) begin
         cvld_in[cnt_addr] = 1'b1;
      end
      if (rd_en) begin
         raddr_in = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jvld_ff  <= '0;
         cvld_ff  <= '0;
         raddr_ff <= '0;
      end else begin
         jvld_ff  <= jvld_in;
         cvld_ff  <= cvld_in;
         raddr_ff <= raddr_in;
      end
   end

   // a count never written reads as zero
   assign rd_entry  = entry_q_ff;
   assign rd_jvalid = jvld_ff[raddr_ff];
   assign rd_count  = cvld_ff[raddr_ff] ? cnt_q_ff : 16'd0;

endmodule

// ----- src/mtjs_slot_bank.sv -----
module mtjs_slot_bank #(
   parameter int SLOT_COUNT = mtjs_pkg::SLOT_COUNT_DEF,
   parameter int AW         = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mtjs_pkg::slot_ctl_type ctl,
   output logic                   full,
   output logic [AW-1:0]          active
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [15:0]           left_ff [SLOT_COUNT];
   logic [15:0]           left_in [SLOT_COUNT];
   logic [SW-1:0]         sel;
   logic                  found;

   // lowest free slot
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (!found && !busy_ff[s]) begin
            found = 1'b1;
            sel   = SW'(s);
         end
      end
   end

   assign full = &busy_ff;

   always_comb begin
      busy_in = busy_ff;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         left_in[s] = left_ff[s];
      end
      if (ctl.alloc && found) begin
         busy_in[sel] = 1'b1;
         left_in[sel] = ctl.dur;
      end
      if (ctl.decay) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            if (busy_ff[s]) begin
               if (left_ff[s] == 16'd0) begin
                  busy_in[s] = 1'b0;
               end else begin
                  left_in[s] = left_ff[s] - 16'd1;
               end
            end
         end
      end
   end

   always_comb begin
      active = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         active = active + AW'(busy_ff[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
         left_ff[s] <= left_in[s];
      end
   end

endmodule
